@@ hdl/rti_pkg.sv @@
// ----------------------------------------------------------------------------
// rti_pkg
// Shared constants, payload types and helpers of the ray/triangle core.
// ----------------------------------------------------------------------------
package rti_pkg;

  localparam int COORD_BITS    = 21;
  localparam int DIST_BITS     = 32;
  localparam int SLOT_BITS     = 21;
  localparam int VEC_BITS      = 3 * SLOT_BITS;
  localparam int FRAC_BITS     = 16;
  localparam int OUT_DIST_BITS = 32;

  // Edge and offset components, cross terms, products and dot-product sums.
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int CROSS_BITS = 2 * DIFF_BITS + 1;
  localparam int PROD_BITS  = DIFF_BITS + CROSS_BITS;
  localparam int SUM_BITS   = PROD_BITS + 2;
  localparam int REM_BITS   = SUM_BITS + DIST_BITS;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] ST_HIT      = 2'd0;
  localparam logic [1:0] ST_PARALLEL = 2'd1;
  localparam logic [1:0] ST_OUTSIDE  = 2'd2;
  localparam logic [1:0] ST_BEHIND   = 2'd3;

  localparam logic [1:0] CFG_VERTEX_ONE   = 2'd0;
  localparam logic [1:0] CFG_VERTEX_TWO   = 2'd1;
  localparam logic [1:0] CFG_VERTEX_THREE = 2'd2;

  typedef struct packed {
    logic [VEC_BITS-1:0] ray_origin;
    logic [VEC_BITS-1:0] ray_direction;
  } ray_in_t;

  typedef struct packed {
    logic [1:0]               hit_status;
    logic [OUT_DIST_BITS-1:0] hit_distance;
  } ray_out_t;

  // One classified ray waiting for its distance to be divided out.
  typedef struct packed {
    logic [1:0]          status;
    logic                ovf;
    logic [SUM_BITS-1:0] num;
    logic [SUM_BITS-1:0] den;
  } rti_job_t;

  // Coordinate k of a packed vector, sign-extended by one bit.
  function automatic logic signed [DIFF_BITS-1:0] coord(input logic [VEC_BITS-1:0] p,
                                                        input int k);
    logic [SLOT_BITS-1:0] slot;
    slot = p[k*SLOT_BITS +: SLOT_BITS];
    return signed'({{(DIFF_BITS-COORD_BITS){slot[COORD_BITS-1]}}, slot[COORD_BITS-1:0]});
  endfunction

endpackage

@@ hdl/rti_front.sv @@
// ----------------------------------------------------------------------------
// rti_front
// Six-stage pipeline: edges, cross terms, products, determinant and
// numerators, sign normalization, and exact hit classification.
// ----------------------------------------------------------------------------
module rti_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  rti_pkg::ray_in_t           in_data,
  input  logic [rti_pkg::VEC_BITS-1:0] vertex_one,
  input  logic [rti_pkg::VEC_BITS-1:0] vertex_two,
  input  logic [rti_pkg::VEC_BITS-1:0] vertex_three,
  output logic                       job_valid,
  input  logic                       job_ready,
  output rti_pkg::rti_job_t          job
);

  localparam int DW = rti_pkg::DIFF_BITS;
  localparam int CW = rti_pkg::CROSS_BITS;
  localparam int PW = rti_pkg::PROD_BITS;
  localparam int NW = rti_pkg::SUM_BITS;
  localparam int RW = rti_pkg::REM_BITS;

  function automatic logic signed [CW-1:0] cross_term(input logic signed [DW-1:0] a,
                                                      input logic signed [DW-1:0] b,
                                                      input logic signed [DW-1:0] c,
                                                      input logic signed [DW-1:0] d);
    logic signed [CW-1:0] pa;
    logic signed [CW-1:0] pb;
    pa = a * b;
    pb = c * d;
    return pa - pb;
  endfunction

  logic en;
  logic val1, val2, val3, val4, val5, val6;

  logic signed [DW-1:0] ea1 [3], eb1 [3], dir1 [3], to1 [3];
  logic signed [DW-1:0] ea2 [3], eb2 [3], dir2 [3], to2 [3];
  logic signed [CW-1:0] c2 [3], s2 [3];
  logic signed [PW-1:0] pd3 [3], pb3 [3], pg3 [3], pt3 [3];
  logic signed [NW-1:0] det4, nb4, ng4, nt4;
  logic signed [NW-1:0] det5, nb5, ng5, nt5, dmb5;
  logic                 zero5;
  logic                 ovf_cmp;

  rti_pkg::rti_job_t job6;

  assign en       = !val6 || job_ready;
  assign in_ready = en;
  assign job_valid = val6;
  assign job      = job6;

  always_ff @(posedge clk) begin
    if (rst) begin
      val1 <= 1'b0;
      val2 <= 1'b0;
      val3 <= 1'b0;
      val4 <= 1'b0;
      val5 <= 1'b0;
      val6 <= 1'b0;
    end else if (en) begin
      val1 <= in_valid;
      val2 <= val1;
      val3 <= val2;
      val4 <= val3;
      val5 <= val4;
      val6 <= val5;
    end
  end

  assign ovf_cmp = RW'($unsigned(nt5)) >= (RW'($unsigned(det5))
                   << (rti_pkg::DIST_BITS - rti_pkg::FRAC_BITS));

  always_ff @(posedge clk) begin
    if (en) begin
      // Stage 1: edges from vertex one, direction, and offset to vertex one.
      for (int k = 0; k < 3; k++) begin
        ea1[k]  <= rti_pkg::coord(vertex_one, k) - rti_pkg::coord(vertex_two, k);
        eb1[k]  <= rti_pkg::coord(vertex_one, k) - rti_pkg::coord(vertex_three, k);
        dir1[k] <= rti_pkg::coord(in_data.ray_direction, k);
        to1[k]  <= rti_pkg::coord(vertex_one, k) - rti_pkg::coord(in_data.ray_origin, k);
      end

      // Stage 2: cross products eb x dir and ea x to.
      c2[0] <= cross_term(eb1[1], dir1[2], dir1[1], eb1[2]);
      c2[1] <= cross_term(dir1[0], eb1[2], eb1[0], dir1[2]);
      c2[2] <= cross_term(eb1[0], dir1[1], eb1[1], dir1[0]);
      s2[0] <= cross_term(ea1[0], to1[1], to1[0], ea1[1]);
      s2[1] <= cross_term(to1[0], ea1[2], ea1[0], to1[2]);
      s2[2] <= cross_term(ea1[1], to1[2], to1[1], ea1[2]);
      for (int k = 0; k < 3; k++) begin
        ea2[k]  <= ea1[k];
        eb2[k]  <= eb1[k];
        dir2[k] <= dir1[k];
        to2[k]  <= to1[k];
      end

      // Stage 3: the twelve products of the four dot products.
      for (int k = 0; k < 3; k++) begin
        pd3[k] <= ea2[k] * c2[k];
        pb3[k] <= to2[k] * c2[k];
        pg3[k] <= dir2[2-k] * s2[k];
        pt3[k] <= eb2[2-k] * s2[k];
      end

      // Stage 4: determinant and the numerators of beta, gamma and t.
      det4 <= NW'(pd3[0]) + NW'(pd3[1]) + NW'(pd3[2]);
      nb4  <= NW'(pb3[0]) + NW'(pb3[1]) + NW'(pb3[2]);
      ng4  <= NW'(pg3[0]) + NW'(pg3[1]) + NW'(pg3[2]);
      nt4  <= -(NW'(pt3[0]) + NW'(pt3[1]) + NW'(pt3[2]));

      // Stage 5: make the determinant positive so the tests need no division.
      zero5 <= det4 == '0;
      if (det4[NW-1]) begin
        det5 <= -det4;
        nb5  <= -nb4;
        ng5  <= -ng4;
        nt5  <= -nt4;
        dmb5 <= nb4 - det4;
      end else begin
        det5 <= det4;
        nb5  <= nb4;
        ng5  <= ng4;
        nt5  <= nt4;
        dmb5 <= det4 - nb4;
      end

      // Stage 6: classification and the saturation test of the distance.
      priority if (zero5) begin
        job6.status <= rti_pkg::ST_PARALLEL;
      end else if (nb5[NW-1] || dmb5[NW-1]) begin
        job6.status <= rti_pkg::ST_OUTSIDE;
      end else if (ng5[NW-1] || ((dmb5 - ng5) < 0)) begin
        job6.status <= rti_pkg::ST_OUTSIDE;
      end else if (nt5[NW-1]) begin
        job6.status <= rti_pkg::ST_BEHIND;
      end else begin
        job6.status <= rti_pkg::ST_HIT;
      end
      job6.ovf <= ovf_cmp;
      job6.num <= $unsigned(nt5);
      job6.den <= $unsigned(det5);
    end
  end

endmodule

@@ hdl/rti_queue.sv @@
// ----------------------------------------------------------------------------
// rti_queue
// Small register FIFO that decouples classification from division.
// ----------------------------------------------------------------------------
module rti_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  rti_pkg::rti_job_t push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output rti_pkg::rti_job_t pop_data
);

  localparam int AW = rti_pkg::QUEUE_AW;

  rti_pkg::rti_job_t mem [rti_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;
  logic          push;
  logic          pop;

  assign push_ready = count != (AW+1)'(rti_pkg::QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

@@ hdl/rti_divider.sv @@
// ----------------------------------------------------------------------------
// rti_divider
// Pipelined restoring divider, one quotient bit per stage, that turns the
// distance numerator and determinant into unsigned Q16.16 and drives the
// result register.
// ----------------------------------------------------------------------------
module rti_divider (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  output logic              job_ready,
  input  rti_pkg::rti_job_t job,
  output logic              out_valid,
  input  logic              out_ready,
  output rti_pkg::ray_out_t out_data
);

  localparam int D  = rti_pkg::DIST_BITS;
  localparam int NW = rti_pkg::SUM_BITS;
  localparam int RW = rti_pkg::REM_BITS;

  logic          en;
  logic          bval [D];
  logic [RW-1:0] brem [D];
  logic [NW-1:0] bden [D];
  logic [D-1:0]  bq   [D];
  logic [1:0]    bst  [D];
  logic          bovf [D];
  logic [RW:0]   trial [D];

  logic          fin_valid;
  logic [1:0]    fin_status;
  logic          fin_ovf;
  logic [D-1:0]  fin_q;
  logic [D-1:0]  dist_sel;
  logic [D+rti_pkg::OUT_DIST_BITS-1:0] dist_ext;

  assign en        = !fin_valid || out_ready;
  assign job_ready = en;

  // Stage k decides quotient bit D-1-k.
  always_comb begin
    for (int k = 0; k < D; k++) begin
      trial[k] = {1'b0, brem[k]} - ((RW+1)'(bden[k]) << (D - 1 - k));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < D; k++) begin
        bval[k] <= 1'b0;
      end
      fin_valid <= 1'b0;
    end else if (en) begin
      bval[0] <= job_valid;
      for (int k = 1; k < D; k++) begin
        bval[k] <= bval[k-1];
      end
      fin_valid <= bval[D-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      brem[0] <= RW'({job.num, {rti_pkg::FRAC_BITS{1'b0}}});
      bden[0] <= job.den;
      bq[0]   <= '0;
      bst[0]  <= job.status;
      bovf[0] <= job.ovf;
      for (int k = 0; k < D - 1; k++) begin
        brem[k+1] <= trial[k][RW] ? brem[k] : trial[k][RW-1:0];
        bq[k+1]   <= {bq[k][D-2:0], !trial[k][RW]};
        bden[k+1] <= bden[k];
        bst[k+1]  <= bst[k];
        bovf[k+1] <= bovf[k];
      end
      fin_q      <= {bq[D-1][D-2:0], !trial[D-1][RW]};
      fin_status <= bst[D-1];
      fin_ovf    <= bovf[D-1];
    end
  end

  assign dist_sel = (fin_status == rti_pkg::ST_HIT && !fin_ovf) ? fin_q : '1;
  assign dist_ext = {{rti_pkg::OUT_DIST_BITS{1'b0}}, dist_sel};

  assign out_valid             = fin_valid;
  assign out_data.hit_status   = fin_status;
  assign out_data.hit_distance = dist_ext[rti_pkg::OUT_DIST_BITS-1:0];

endmodule

@@ hdl/ray_triangle_intersect_core.sv @@
// ----------------------------------------------------------------------------
// ray_triangle_intersect_core
// Ray against one configured triangle by Cramer's rule, fixed point.
// ----------------------------------------------------------------------------
// The core accepts one ray per clock unless stalled and returns one result per
// ray, in order, after 6 classification stages, the queue, 32 divider stages
// and the result register. In the fully pipelined datapath, the front's
// 12 product multipliers and the back's one-bit-per-stage divider each take a
// new ray every cycle unless stalled. A four-entry queue lets the two halves
// stall independently. The user must write vertices through the configuration
// channel only while no ray is in flight (not enforced); it is always ready.
module ray_triangle_intersect_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  rti_pkg::ray_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output rti_pkg::ray_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [rti_pkg::VEC_BITS-1:0] cfg_data
);

  logic [rti_pkg::VEC_BITS-1:0] vertex_one;
  logic [rti_pkg::VEC_BITS-1:0] vertex_two;
  logic [rti_pkg::VEC_BITS-1:0] vertex_three;

  logic              f_valid, f_ready;
  rti_pkg::rti_job_t f_job;
  logic              q_valid, q_ready;
  rti_pkg::rti_job_t q_job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_one   <= '0;
      vertex_two   <= '0;
      vertex_three <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rti_pkg::CFG_VERTEX_ONE:   vertex_one   <= cfg_data;
        rti_pkg::CFG_VERTEX_TWO:   vertex_two   <= cfg_data;
        rti_pkg::CFG_VERTEX_THREE: vertex_three <= cfg_data;
        default: ;
      endcase
    end
  end

  rti_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .vertex_one   (vertex_one),
    .vertex_two   (vertex_two),
    .vertex_three (vertex_three),
    .job_valid    (f_valid),
    .job_ready    (f_ready),
    .job          (f_job)
  );

  rti_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_job),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_job)
  );

  rti_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_valid),
    .job_ready (q_ready),
    .job       (q_job),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
